[sv/qrk4_pkg.sv]
// Shared types, constants and helper functions of the quaternion RK4 integrator.
`timescale 1ns / 1ps
`default_nettype none

package qrk4_pkg;

    localparam int Q_W    = 32;
    localparam int NUM_W  = 61;
    localparam int DEN_W  = 32;
    localparam int CNT_W  = 6;
    localparam int SQRT_STEPS = 32;
    localparam int D6_STEPS   = 4;
    localparam logic [11:0] D6_RECIP = 12'd2731;
    localparam logic signed [Q_W-1:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [Q_W-1:0] MAX_Q   = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] MIN_Q   = 32'sh8000_0000;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_MUL_TERM,
        OP_ACC_TERM,
        OP_DSET,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_KFIN,
        OP_UPD,
        OP_DIV6_START,
        OP_DIV6_STEP,
        OP_DIV6_FIN,
        OP_MUL_SQ,
        OP_SQ_ACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_NDIV_START,
        OP_NDIV_FIN,
        OP_IDENT,
        OP_PUBLISH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
        logic [3:0] term;
        logic [1:0] sub;
        logic [1:0] stage;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic ss_zero;
    } t_status;

    // quaternion index of product term t of the derivative
    function automatic logic [1:0] term_q(input logic [3:0] t);
        logic [1:0] r;
        unique case (t)
            4'd0, 4'd3, 4'd6: r = 2'd3;
            4'd1, 4'd8, 4'd10: r = 2'd1;
            4'd2, 4'd4, 4'd11: r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // omega index of product term t
    function automatic logic [1:0] term_om(input logic [3:0] t);
        logic [1:0] r;
        unique case (t)
            4'd0, 4'd4, 4'd8, 4'd9: r = 2'd0;
            4'd2, 4'd3, 4'd7, 4'd10: r = 2'd1;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic term_neg(input logic [3:0] t);
        logic r;
        unique case (t)
            4'd2, 4'd5, 4'd8, 4'd9, 4'd10, 4'd11: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = MAX_Q;
        end else if (v < -64'sd2147483648) begin
            r = MIN_Q;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/qrk4_divider.sv]
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module qrk4_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [qrk4_pkg::NUM_W-1:0]     i_num,
    input  wire logic [qrk4_pkg::DEN_W-1:0]     i_den,
    output logic      [qrk4_pkg::NUM_W-1:0]     o_quot,
    output logic                                o_done
);

    logic                           r_busy;
    logic                           r_done;
    logic [qrk4_pkg::CNT_W-1:0]     r_cnt;
    logic [qrk4_pkg::NUM_W-1:0]     r_num;
    logic [qrk4_pkg::NUM_W-1:0]     r_quot;
    logic [qrk4_pkg::DEN_W-1:0]     r_den;
    logic [qrk4_pkg::DEN_W-1:0]     r_rem;
    logic [qrk4_pkg::DEN_W:0]       sh;
    logic                           fits;

    assign sh   = {r_rem, r_num[qrk4_pkg::NUM_W-1]};
    assign fits = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == qrk4_pkg::CNT_W'(qrk4_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[qrk4_pkg::NUM_W-2:0], 1'b0};
            r_rem  <= fits ? qrk4_pkg::DEN_W'(sh - {1'b0, r_den})
                           : sh[qrk4_pkg::DEN_W-1:0];
            r_quot <= {r_quot[qrk4_pkg::NUM_W-2:0], fits};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

`default_nettype wire

[sv/qrk4_datapath.sv]
// Datapath: attitude, RK4 slopes, shared multiplier, square root and normalizing divides.
`timescale 1ns / 1ps
`default_nettype none

module qrk4_datapath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire qrk4_pkg::t_cmd         i_cmd,
    input  wire logic [255:0]           i_in_data,
    output qrk4_pkg::t_status           o_status,
    output logic [127:0]                o_out_data,
    output logic                        o_out_degen
);

    logic signed [31:0] r_att [4];
    logic signed [31:0] r_qt [4];
    logic signed [31:0] r_k [4];
    logic signed [34:0] r_ks [4];
    logic signed [31:0] r_om [3];
    logic [31:0]        r_dt;
    logic signed [62:0] r_acc;
    logic signed [39:0] r_d;
    logic signed [56:0] r_a;
    logic signed [73:0] r_prod;
    logic [62:0]        r_ss;
    logic [62:0]        r_sv;
    logic [62:0]        r_res;
    logic [62:0]        r_bit;
    logic [35:0]        r_d6;
    logic [2:0]         r_d6_rem;
    logic               r_dneg;
    logic               r_nneg;
    logic               r_degen;
    logic [127:0]       r_out;
    logic               r_out_degen;

    logic signed [40:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [73:0] prod;
    logic [1:0]         tq;
    logic [1:0]         tom;
    logic [31:0]        mag;
    logic signed [63:0] p_term;
    logic signed [63:0] kb;
    logic signed [63:0] kv;
    logic signed [63:0] kk;
    logic signed [63:0] khalf;
    logic signed [63:0] t6;
    logic signed [63:0] qv;
    logic [63:0]        sq_sum;
    logic [35:0]        d6_mag;
    logic [11:0]        d6_x;
    logic [23:0]        d6_prod;
    logic [8:0]         d6_q;
    logic [2:0]         d6_r;
    logic               div_start;
    logic [60:0]        div_num;
    logic [31:0]        div_den;
    logic [60:0]        quot;
    logic               div_done;

    assign tq  = qrk4_pkg::term_q(i_cmd.term);
    assign tom = qrk4_pkg::term_om(i_cmd.term);
    assign mag = r_qt[i_cmd.idx][31] ? 32'(~r_qt[i_cmd.idx] + 32'sd1)
                                     : 32'(r_qt[i_cmd.idx]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            qrk4_pkg::OP_MUL_TERM: begin
                mul_a = 41'(r_qt[tq]);
                mul_b = 33'(r_om[tom]);
            end
            qrk4_pkg::OP_MUL_HI: begin
                mul_a = 41'(r_d);
                mul_b = signed'({17'b0, r_dt[31:16]});
            end
            qrk4_pkg::OP_MUL_LO: begin
                mul_a = 41'(r_d);
                mul_b = signed'({17'b0, r_dt[15:0]});
            end
            qrk4_pkg::OP_MUL_SQ: begin
                mul_a = signed'({9'b0, mag});
                mul_b = signed'({1'b0, mag});
            end
            default: begin
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // divide by six, 9 bits a step: floor(x / 6) = (x * 2731) >> 14 for x < 3072
    assign d6_x    = {r_d6_rem, r_d6[35:27]};
    assign d6_prod = 24'(d6_x) * 24'(qrk4_pkg::D6_RECIP);
    assign d6_q    = d6_prod[22:14];
    assign d6_r    = 3'(d6_x - 12'(d6_q) * 12'd6);

    always_comb begin
        p_term = 64'(signed'(r_prod[63:0])) >>> 2;
        kb     = 64'(signed'(r_prod[56:0])) + 64'sd2147483648;
        kv     = (64'(r_a) + (kb >>> 16)) >>> 16;
        kk     = 64'(r_k[i_cmd.idx]);
        khalf  = (kk + 64'sd1) >>> 1;
        t6     = 64'(r_ks[i_cmd.idx]) + 64'sd3;
        d6_mag = (t6 < 0) ? 36'(64'sd5 - t6) : 36'(t6);
        qv     = r_dneg ? -signed'({28'b0, r_d6}) : signed'({28'b0, r_d6});
        sq_sum = 64'(r_sv) - 64'(r_res) - 64'(r_bit);
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (i_cmd.op)
            qrk4_pkg::OP_NDIV_START: begin
                div_start = 1'b1;
                div_num   = {mag, 29'b0} + 61'(r_res[31:1]);
                div_den   = r_res[31:0];
            end
            default: begin
            end
        endcase
    end

    qrk4_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    // attitude state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att[0] <= '0;
            r_att[1] <= '0;
            r_att[2] <= '0;
            r_att[3] <= qrk4_pkg::ONE_Q30;
        end else begin
            unique case (i_cmd.op)
                qrk4_pkg::OP_LOAD: begin
                    r_att[0] <= i_in_data[159:128];
                    r_att[1] <= i_in_data[191:160];
                    r_att[2] <= i_in_data[223:192];
                    r_att[3] <= i_in_data[255:224];
                end
                qrk4_pkg::OP_IDENT: begin
                    r_att[0] <= '0;
                    r_att[1] <= '0;
                    r_att[2] <= '0;
                    r_att[3] <= qrk4_pkg::ONE_Q30;
                end
                qrk4_pkg::OP_NDIV_FIN: begin
                    if (r_nneg) begin
                        r_att[i_cmd.idx] <= (quot > 61'd2147483648) ? qrk4_pkg::MIN_Q
                                            : signed'(~quot[31:0] + 32'd1);
                    end else begin
                        r_att[i_cmd.idx] <= (quot > 61'd2147483647) ? qrk4_pkg::MAX_Q
                                            : signed'(quot[31:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            qrk4_pkg::OP_LOAD: begin
                r_degen <= 1'b0;
            end
            qrk4_pkg::OP_START: begin
                r_degen <= 1'b0;
                r_om[0] <= i_in_data[31:0];
                r_om[1] <= i_in_data[63:32];
                r_om[2] <= i_in_data[95:64];
                r_dt    <= i_in_data[127:96];
                for (int i = 0; i < 4; i++) begin
                    r_qt[i] <= r_att[i];
                end
            end
            qrk4_pkg::OP_MUL_TERM, qrk4_pkg::OP_MUL_HI, qrk4_pkg::OP_MUL_SQ: begin
                r_prod <= prod;
            end
            qrk4_pkg::OP_MUL_LO: begin
                r_a    <= r_prod[56:0];
                r_prod <= prod;
            end
            qrk4_pkg::OP_ACC_TERM: begin
                if (i_cmd.sub == 2'd0) begin
                    r_acc <= qrk4_pkg::term_neg(i_cmd.term) ? 63'(-p_term) : 63'(p_term);
                end else begin
                    r_acc <= qrk4_pkg::term_neg(i_cmd.term) ? 63'(64'(r_acc) - p_term)
                                                            : 63'(64'(r_acc) + p_term);
                end
            end
            qrk4_pkg::OP_DSET: begin
                r_d <= 40'((64'(r_acc) + 64'sd4194304) >>> 23);
            end
            qrk4_pkg::OP_KFIN: begin
                r_k[i_cmd.idx] <= qrk4_pkg::sat32(kv);
            end
            qrk4_pkg::OP_UPD: begin
                unique case (i_cmd.stage)
                    2'd0: begin
                        r_ks[i_cmd.idx] <= 35'(kk);
                        r_qt[i_cmd.idx] <= qrk4_pkg::sat32(64'(r_att[i_cmd.idx]) + khalf);
                    end
                    2'd1: begin
                        r_ks[i_cmd.idx] <= 35'(64'(r_ks[i_cmd.idx]) + 2 * kk);
                        r_qt[i_cmd.idx] <= qrk4_pkg::sat32(64'(r_att[i_cmd.idx]) + khalf);
                    end
                    2'd2: begin
                        r_ks[i_cmd.idx] <= 35'(64'(r_ks[i_cmd.idx]) + 2 * kk);
                        r_qt[i_cmd.idx] <= qrk4_pkg::sat32(64'(r_att[i_cmd.idx]) + kk);
                    end
                    default: begin
                        r_ks[i_cmd.idx] <= 35'(64'(r_ks[i_cmd.idx]) + kk);
                    end
                endcase
            end
            qrk4_pkg::OP_DIV6_START: begin
                r_dneg   <= t6 < 0;
                r_d6     <= d6_mag;
                r_d6_rem <= '0;
            end
            qrk4_pkg::OP_DIV6_STEP: begin
                r_d6     <= {r_d6[26:0], d6_q};
                r_d6_rem <= d6_r;
            end
            qrk4_pkg::OP_DIV6_FIN: begin
                r_qt[i_cmd.idx] <= qrk4_pkg::sat32(64'(r_att[i_cmd.idx]) + qv);
            end
            qrk4_pkg::OP_SQ_ACC: begin
                r_ss <= ((i_cmd.idx == 2'd0) ? 63'd0 : r_ss) + 63'(r_prod[63:2]);
            end
            qrk4_pkg::OP_SQRT_INIT: begin
                r_sv  <= r_ss;
                r_res <= '0;
                r_bit <= 63'd1 << 62;
            end
            qrk4_pkg::OP_SQRT_STEP: begin
                if (!sq_sum[63]) begin
                    r_sv  <= sq_sum[62:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            qrk4_pkg::OP_NDIV_START: begin
                r_nneg <= r_qt[i_cmd.idx][31];
            end
            qrk4_pkg::OP_IDENT: begin
                r_degen <= 1'b1;
            end
            qrk4_pkg::OP_PUBLISH: begin
                r_out       <= {r_att[3], r_att[2], r_att[1], r_att[0]};
                r_out_degen <= r_degen;
            end
            default: begin
            end
        endcase
    end

    assign o_status.div_done = div_done;
    assign o_status.ss_zero  = r_ss == '0;
    assign o_out_data        = r_out;
    assign o_out_degen       = r_out_degen;

endmodule

`default_nettype wire

[sv/qrk4_ctrl.sv]
// Controller: sequences the RK4 step, norm, square root and divides on the datapath.
`timescale 1ns / 1ps
`default_nettype none

module qrk4_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_req_type,
    input  wire logic               i_out_ready,
    input  wire qrk4_pkg::t_status  i_status,
    output qrk4_pkg::t_cmd          o_cmd,
    output logic                    o_in_ready,
    output logic                    o_out_valid
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_TERM_MUL,
        S_TERM_ACC,
        S_DSET,
        S_MHI,
        S_MLO,
        S_KFIN,
        S_UPD,
        S_D6_START,
        S_D6_STEP,
        S_D6_FIN,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQ_CHK,
        S_SQRT_INIT,
        S_SQRT,
        S_ND_START,
        S_ND_WAIT,
        S_ND_FIN,
        S_IDENT,
        S_PUB
    } t_state;

    t_state                     r_state;
    logic [1:0]                 r_i;
    logic [1:0]                 r_sub;
    logic [1:0]                 r_stage;
    logic [qrk4_pkg::CNT_W-1:0] r_cnt;
    logic                       r_out_valid;
    logic                       publish;

    assign publish = (r_state == S_PUB) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd.op    = qrk4_pkg::OP_NONE;
        o_cmd.idx   = r_i;
        o_cmd.term  = 4'(4'(r_i) * 4'd3 + 4'(r_sub));
        o_cmd.sub   = r_sub;
        o_cmd.stage = r_stage;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.op = i_req_type ? qrk4_pkg::OP_START : qrk4_pkg::OP_LOAD;
                end
            end
            S_TERM_MUL:  o_cmd.op = qrk4_pkg::OP_MUL_TERM;
            S_TERM_ACC:  o_cmd.op = qrk4_pkg::OP_ACC_TERM;
            S_DSET:      o_cmd.op = qrk4_pkg::OP_DSET;
            S_MHI:       o_cmd.op = qrk4_pkg::OP_MUL_HI;
            S_MLO:       o_cmd.op = qrk4_pkg::OP_MUL_LO;
            S_KFIN:      o_cmd.op = qrk4_pkg::OP_KFIN;
            S_UPD:       o_cmd.op = qrk4_pkg::OP_UPD;
            S_D6_START:  o_cmd.op = qrk4_pkg::OP_DIV6_START;
            S_D6_STEP:   o_cmd.op = qrk4_pkg::OP_DIV6_STEP;
            S_D6_FIN:    o_cmd.op = qrk4_pkg::OP_DIV6_FIN;
            S_SQ_MUL:    o_cmd.op = qrk4_pkg::OP_MUL_SQ;
            S_SQ_ACC:    o_cmd.op = qrk4_pkg::OP_SQ_ACC;
            S_SQRT_INIT: o_cmd.op = qrk4_pkg::OP_SQRT_INIT;
            S_SQRT:      o_cmd.op = qrk4_pkg::OP_SQRT_STEP;
            S_ND_START:  o_cmd.op = qrk4_pkg::OP_NDIV_START;
            S_ND_FIN:    o_cmd.op = qrk4_pkg::OP_NDIV_FIN;
            S_IDENT:     o_cmd.op = qrk4_pkg::OP_IDENT;
            S_PUB: begin
                if (publish) begin
                    o_cmd.op = qrk4_pkg::OP_PUBLISH;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_sub       <= '0;
            r_stage     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_i     <= '0;
                        r_sub   <= '0;
                        r_stage <= '0;
                        r_state <= i_req_type ? S_TERM_MUL : S_PUB;
                    end
                end
                S_TERM_MUL: r_state <= S_TERM_ACC;
                S_TERM_ACC: begin
                    if (r_sub == 2'd2) begin
                        r_state <= S_DSET;
                    end else begin
                        r_sub   <= r_sub + 1'b1;
                        r_state <= S_TERM_MUL;
                    end
                end
                S_DSET: r_state <= S_MHI;
                S_MHI:  r_state <= S_MLO;
                S_MLO:  r_state <= S_KFIN;
                S_KFIN: begin
                    r_sub <= '0;
                    r_i   <= r_i + 1'b1;
                    r_state <= (r_i == 2'd3) ? S_UPD : S_TERM_MUL;
                end
                S_UPD: begin
                    if (r_stage == 2'd3) begin
                        r_state <= S_D6_START;
                    end else if (r_i == 2'd3) begin
                        r_i     <= '0;
                        r_stage <= r_stage + 1'b1;
                        r_state <= S_TERM_MUL;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_D6_START: begin
                    r_cnt   <= '0;
                    r_state <= S_D6_STEP;
                end
                S_D6_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == qrk4_pkg::CNT_W'(qrk4_pkg::D6_STEPS - 1)) begin
                        r_state <= S_D6_FIN;
                    end
                end
                S_D6_FIN: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= (r_i == 2'd3) ? S_SQ_MUL : S_UPD;
                end
                S_SQ_MUL: r_state <= S_SQ_ACC;
                S_SQ_ACC: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= (r_i == 2'd3) ? S_SQ_CHK : S_SQ_MUL;
                end
                S_SQ_CHK: r_state <= i_status.ss_zero ? S_IDENT : S_SQRT_INIT;
                S_SQRT_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == qrk4_pkg::CNT_W'(qrk4_pkg::SQRT_STEPS - 1)) begin
                        r_state <= S_ND_START;
                    end
                end
                S_ND_START: r_state <= S_ND_WAIT;
                S_ND_WAIT: begin
                    if (i_status.div_done) begin
                        r_state <= S_ND_FIN;
                    end
                end
                S_ND_FIN: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= (r_i == 2'd3) ? S_PUB : S_ND_START;
                end
                S_IDENT: r_state <= S_PUB;
                S_PUB: begin
                    if (publish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[sv/quaternion_rk4_integrator.sv]
// Top level of the quaternion RK4 attitude integrator.
`timescale 1ns / 1ps
`default_nettype none

// Holds an attitude quaternion (Q2.30, identity after reset). An item with
// tuser 0 loads the four components as given; an item with tuser 1 runs one
// RK4 step with the given body rate and time step, then renormalizes: four
// slopes on one shared multiplier, slope updates including the division by
// six (per component, by reciprocal multiplication), the squared norm and its
// 32-step square root, and four bit-serial normalizing divides, which
// dominate. A zero norm skips the root and the divides. One item is worked on
// at a time; the next item is taken while the previous result still waits in
// the output register. Each item gives one result: the quaternion after the
// request and a degenerate flag.

module quaternion_rk4_integrator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // omega_x, omega_y, omega_z, step_time, load_x, load_y, load_z, load_w
    input  wire logic [255:0]   s_axis_tdata,
    // req_type
    input  wire logic           s_axis_tuser,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [127:0]        m_axis_tdata,
    // degenerate
    output logic                m_axis_tuser
);

    qrk4_pkg::t_cmd     cmd;
    qrk4_pkg::t_status  status;
    logic               accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    qrk4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    qrk4_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (s_axis_tdata),
        .o_status    (status),
        .o_out_data  (m_axis_tdata),
        .o_out_degen (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("input ready while an item is in work");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser && !m_axis_tvalid) |-> ##2 m_axis_tvalid)
        else $error("load result not presented");

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata == {qrk4_pkg::ONE_Q30, 96'd0}))
        else $error("degenerate result is not identity");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_qrk4_pkg.sv]
// Request codes and the expected-result type used by the integrator testbench files.
`timescale 1ns / 1ps

package tb_qrk4_pkg;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic [3:0][31:0] q;
        logic             degen;
    } t_attitude_res;

endpackage

[tb/sv/attitude_checker.sv]
// Checker: predicts the attitude after each request and compares the results.
`timescale 1ns / 1ps

module attitude_checker
    import tb_qrk4_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [255:0] i_s_tdata,
    input  wire logic         i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [127:0] i_m_tdata,
    input  wire logic         i_m_tuser,
    output int                o_fails,
    output int                o_pending
);

    longint        att[4];
    t_attitude_res expected_att[$];

    assign o_pending = expected_att.size();

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (64'sd1 << (n - 1))) >>> n;
    endfunction

    function automatic longint pr(input longint a, input longint b);
        return (a * b) >>> 2;
    endfunction

    // k = q * (om, 0) / 2 * dt
    function automatic void rate_slope(input longint q[4], input longint om[3],
                                       input longint dt, output longint k[4]);
        longint s[4];
        longint d, hi, lo, a, b;
        hi = dt >> 16;
        lo = dt & 64'hffff;
        s[0] = pr(q[3], om[0]) + pr(q[1], om[2]) - pr(q[2], om[1]);
        s[1] = pr(q[3], om[1]) + pr(q[2], om[0]) - pr(q[0], om[2]);
        s[2] = pr(q[3], om[2]) + pr(q[0], om[1]) - pr(q[1], om[0]);
        s[3] = -(pr(q[0], om[0]) + pr(q[1], om[1]) + pr(q[2], om[2]));
        for (int i = 0; i < 4; i++) begin
            d = rnd_shift(s[i], 23);
            a = d * hi;
            b = d * lo + (64'sd1 << 31);
            k[i] = sat32((a + (b >>> 16)) >>> 16);
        end
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint div6_round(input longint s);
        longint t;
        t = s + 3;
        if (t >= 0) return t / 6;
        return -((-t + 5) / 6);
    endfunction

    function automatic logic rk4_advance(input longint om[3], input longint dt);
        longint q1[4], qt[4], k1[4], k2[4], k3[4], k4[4], qn[4];
        longint unsigned ss, r, m, v;
        longint sv;
        ss = 0;
        for (int i = 0; i < 4; i++) q1[i] = att[i];
        rate_slope(q1, om, dt, k1);
        for (int i = 0; i < 4; i++) qt[i] = sat32(q1[i] + rnd_shift(k1[i], 1));
        rate_slope(qt, om, dt, k2);
        for (int i = 0; i < 4; i++) qt[i] = sat32(q1[i] + rnd_shift(k2[i], 1));
        rate_slope(qt, om, dt, k3);
        for (int i = 0; i < 4; i++) qt[i] = sat32(q1[i] + k3[i]);
        rate_slope(qt, om, dt, k4);
        for (int i = 0; i < 4; i++) begin
            qn[i] = sat32(q1[i] + div6_round(k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]));
            m = (qn[i] < 0) ? -qn[i] : qn[i];
            ss += (m * m) >> 2;
        end
        if (ss == 0) begin
            att = '{0, 0, 0, 64'sd1 << 30};
            return 1'b1;
        end
        r = int_sqrt(ss);
        for (int i = 0; i < 4; i++) begin
            m = (qn[i] < 0) ? -qn[i] : qn[i];
            v = ((m << 29) + (r >> 1)) / r;
            sv = (v > (64'd1 << 32)) ? (64'sd1 << 32) : longint'(v);
            att[i] = sat32((qn[i] < 0) ? -sv : sv);
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fails++;
    endtask

    always @(posedge i_clk) begin
        t_attitude_res res, exp_res;
        longint        om[3];
        if (!i_rst_n) begin
            att = '{0, 0, 0, 64'sd1 << 30};
            expected_att.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                res.degen = 1'b0;
                if (i_s_tuser == REQ_LOAD) begin
                    for (int i = 0; i < 4; i++)
                        att[i] = longint'($signed(i_s_tdata[128 + 32*i +: 32]));
                end else begin
                    for (int i = 0; i < 3; i++)
                        om[i] = longint'($signed(i_s_tdata[32*i +: 32]));
                    res.degen = rk4_advance(om, longint'({32'd0, i_s_tdata[127:96]}));
                end
                for (int i = 0; i < 4; i++) res.q[i] = att[i][31:0];
                expected_att.push_back(res);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_att.size() == 0) begin
                    report_mismatch("unexpected item", i_m_tdata[31:0], 32'd0);
                end else begin
                    exp_res = expected_att.pop_front();
                    if (i_m_tdata[31:0] !== exp_res.q[0])
                        report_mismatch("quat_x", i_m_tdata[31:0], exp_res.q[0]);
                    if (i_m_tdata[63:32] !== exp_res.q[1])
                        report_mismatch("quat_y", i_m_tdata[63:32], exp_res.q[1]);
                    if (i_m_tdata[95:64] !== exp_res.q[2])
                        report_mismatch("quat_z", i_m_tdata[95:64], exp_res.q[2]);
                    if (i_m_tdata[127:96] !== exp_res.q[3])
                        report_mismatch("quat_w", i_m_tdata[127:96], exp_res.q[3]);
                    if (i_m_tuser !== exp_res.degen)
                        report_mismatch("degenerate", {31'd0, i_m_tuser},
                                        {31'd0, exp_res.degen});
                end
            end
        end
    end

    initial o_fails = 0;

endmodule

[tb/sv/tb.sv]
// Testbench top: drives requests into the RK4 integrator and gives the verdict.
`timescale 1ns / 1ps

module tb;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    int           fails;
    int           pending;
    bit           quiet = 1'b0;
    int           hold_req = 0;

    quaternion_rk4_integrator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    attitude_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .o_fails(fails), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    task automatic send_req(input logic req, input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] dt,
                            input logic [31:0] lx, input logic [31:0] ly,
                            input logic [31:0] lz, input logic [31:0] lw);
        if (!quiet && $urandom_range(0, 99) < 29) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 29);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {lw, lz, ly, lx, dt, oz, oy, ox};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic load_quat(input logic [31:0] lx, input logic [31:0] ly,
                             input logic [31:0] lz, input logic [31:0] lw);
        send_req(tb_qrk4_pkg::REQ_LOAD, $urandom, $urandom, $urandom, $urandom,
                 lx, ly, lz, lw);
    endtask

    task automatic step_quat(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [31:0] dt);
        send_req(tb_qrk4_pkg::REQ_STEP, ox, oy, oz, dt,
                 $urandom, $urandom, $urandom, $urandom);
    endtask

    function automatic logic [31:0] near_unit();
        return $unsigned($signed($urandom) >>> 2);
    endfunction

    function automatic logic [31:0] rand_rate();
        if ($urandom_range(0, 9) < 2) return $urandom;
        return $unsigned($signed($urandom) >>> $urandom_range(4, 12));
    endfunction

    function automatic logic [31:0] rand_dt();
        if ($urandom_range(0, 9) < 2) return $urandom;
        return $urandom >> $urandom_range(4, 16);
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        step_quat(32'd0, 32'd0, 32'd0, 32'd0);
        step_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
        step_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        load_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        step_quat(32'h0100_0000, 32'hff00_0000, 32'h0080_0000, 32'h0100_0000);
        load_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        step_quat(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff);
        load_quat(32'd0, 32'd0, 32'd0, 32'd0);
        step_quat(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
        load_quat(32'd1, 32'hffff_ffff, 32'd1, 32'hffff_ffff);
        step_quat(32'd0, 32'd0, 32'd0, 32'd0);
        load_quat(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        step_quat(32'hffff_ffff, 32'd1, 32'hffff_ffff, 32'd1);
        load_quat(32'd0, 32'd0, 32'd0, 32'h4000_0000);
        step_quat(32'h0100_0000, 32'd0, 32'd0, 32'h028f_5c29);
        step_quat(32'd0, 32'h7fff_ffff, 32'd0, 32'h8000_0000);
        load_quat(32'h2000_0000, 32'he000_0000, 32'h2000_0000, 32'h2000_0000);
        step_quat(32'h0324_3f6a, 32'hfcdb_c096, 32'h0001_0000, 32'h0000_ffff);

        for (int n = 0; n < 700; n++) begin
            if (n == 150) hold_req = 3000;
            quiet = (n >= 300 && n < 380);
            if (n == 450) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 3) begin
                if ($urandom_range(0, 1) == 0)
                    load_quat($urandom, $urandom, $urandom, $urandom);
                else
                    load_quat(near_unit(), near_unit(), near_unit(), near_unit());
            end else begin
                step_quat(rand_rate(), rand_rate(), rand_rate(), rand_dt());
            end
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #25ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
